>>> src/tfp_pkg.sv
package tfp_pkg;

    // Field widths
    localparam int CLOCK_W  = 24;
    localparam int FREQ_W   = 20;
    localparam int PERIOD_W = 11;
    localparam int CFG_IDX_W = 2;

    // Quotient bits resolved by the divider; anything at or above 2**QUO_W saturates
    localparam int QUO_W = PERIOD_W;
    // Remainder lives in FREQ_W bits; compares run at full shifted divisor width
    localparam int WIDE_W = FREQ_W + QUO_W;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
    localparam logic [CLOCK_W-1:0]  CLOCK_RESET = 24'd894080;

    // Divisor 16*f or 32*f is folded into a right shift of the base clock
    localparam int PULSE_SHIFT    = 4;
    localparam int TRIANGLE_SHIFT = 5;

    // Channel kind codes
    localparam logic CMD_PULSE    = 1'b0;
    localparam logic CMD_TRIANGLE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_BASE = 2'd1;

    // Payload carried down the divider pipeline
    typedef struct packed {
        logic [FREQ_W-1:0] rem;
        logic [FREQ_W-1:0] freq;
        logic [QUO_W-1:0]  quo;
        logic              sat;
    } tfp_work_t;

    // One pipeline slot: valid bit travels with the payload
    typedef struct packed {
        logic      valid;
        tfp_work_t work;
    } tfp_stage_t;

endpackage

>>> src/tone_frequency_to_timer_period_unit.sv
// A request is registered in prep at accept, then in 11 divide stages and the output register.
// Throughput: one request per cycle unless stalled; each divide stage resolves one quotient bit.
// Stalls back up stage by stage, so bubbles are absorbed before in_stall rises.
// Reset (rst_n, async, active low) empties the pipeline and sets both base clocks
// to 894080 Hz.
module tone_frequency_to_timer_period_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfp_pkg::CLOCK_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  logic [tfp_pkg::FREQ_W-1:0]      freq_hz,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tfp_pkg::PERIOD_W-1:0]    timer_period
);
    import tfp_pkg::*;

    logic [CLOCK_W-1:0] pulse_base;
    logic [CLOCK_W-1:0] triangle_base;
    logic               prep_ready;
    tfp_stage_t         stage [0:QUO_W];
    logic               stage_ready [0:QUO_W];

    // Base clock registers
    tfp_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pulse_base    (pulse_base),
        .triangle_base (triangle_base)
    );

    // Operand select, shift and saturation check
    tfp_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .command       (command),
        .freq_hz       (freq_hz),
        .pulse_base    (pulse_base),
        .triangle_base (triangle_base),
        .next_ready    (stage_ready[0]),
        .ready         (prep_ready),
        .stage_out     (stage[0])
    );

    assign in_stall = !prep_ready;

    // Divider: one quotient bit per stage, MSB first
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        tfp_div_step #(
            .BIT_POS (QUO_W - 1 - k)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .stage_in   (stage[k]),
            .next_ready (stage_ready[k+1]),
            .ready      (stage_ready[k]),
            .stage_out  (stage[k+1])
        );
    end

    // Output register
    tfp_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_in     (stage[QUO_W]),
        .out_stall    (out_stall),
        .ready        (stage_ready[QUO_W]),
        .out_valid    (out_valid),
        .timer_period (timer_period)
    );

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("pipeline stalled while output drains");

endmodule

>>> src/tfp_cfg.sv
module tfp_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tfp_pkg::CLOCK_W-1:0]      cfg_data,
    output logic [tfp_pkg::CLOCK_W-1:0]      pulse_base,
    output logic [tfp_pkg::CLOCK_W-1:0]      triangle_base
);
    import tfp_pkg::*;

    logic [CLOCK_W-1:0] pulse_base_reg;
    logic [CLOCK_W-1:0] triangle_base_reg;

    // Base clock registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_base_reg    <= CLOCK_RESET;
            triangle_base_reg <= CLOCK_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PULSE_BASE)
                pulse_base_reg <= cfg_data;
            if (cfg_index == CFG_TRIANGLE_BASE)
                triangle_base_reg <= cfg_data;
        end
    end

    assign pulse_base    = pulse_base_reg;
    assign triangle_base = triangle_base_reg;

    a_pulse_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == CFG_PULSE_BASE |=> pulse_base_reg == $past(cfg_data))
        else $error("pulse base write lost");

    a_triangle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_we && cfg_index == CFG_TRIANGLE_BASE) |=> $stable(triangle_base_reg))
        else $error("triangle base changed without a write");

endmodule

>>> src/tfp_prep.sv
module tfp_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          command,
    input  logic [tfp_pkg::FREQ_W-1:0]    freq_hz,
    input  logic [tfp_pkg::CLOCK_W-1:0]   pulse_base,
    input  logic [tfp_pkg::CLOCK_W-1:0]   triangle_base,
    input  logic                          next_ready,
    output logic                          ready,
    output tfp_pkg::tfp_stage_t           stage_out
);
    import tfp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    tfp_work_t         work_reg;
    tfp_work_t         work_next;
    logic [FREQ_W-1:0] base_shifted;

    assign ready = !valid_reg || next_ready;

    // Scale base clock down by 16 or 32; quotient is unchanged by flooring first
    always_comb
    begin
        if (command == CMD_TRIANGLE)
            base_shifted = FREQ_W'(triangle_base >> TRIANGLE_SHIFT);
        else
            base_shifted = FREQ_W'(pulse_base >> PULSE_SHIFT);
        work_next.rem  = base_shifted;
        work_next.freq = freq_hz;
        work_next.quo  = '0;
        // Quotient >= 2048 (or zero frequency) saturates to the longest period
        work_next.sat  = {{QUO_W{1'b0}}, base_shifted} >= {freq_hz, {QUO_W{1'b0}}};
    end

    assign valid_next = ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
            work_reg <= work_next;
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.work  = work_reg;

endmodule

>>> src/tfp_div_step.sv
module tfp_div_step #(
    parameter int BIT_POS = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tfp_pkg::tfp_stage_t  stage_in,
    input  logic                 next_ready,
    output logic                 ready,
    output tfp_pkg::tfp_stage_t  stage_out
);
    import tfp_pkg::*;

    logic              valid_reg;
    tfp_work_t         work_reg;
    tfp_work_t         work_next;
    logic [WIDE_W-1:0] trial;
    logic [WIDE_W-1:0] rem_wide;
    logic [WIDE_W-1:0] diff;

    assign ready = !valid_reg || next_ready;

    // One restoring step: try subtracting f << BIT_POS
    always_comb
    begin
        trial    = {{QUO_W{1'b0}}, stage_in.work.freq} << BIT_POS;
        rem_wide = {{QUO_W{1'b0}}, stage_in.work.rem};
        diff     = rem_wide - trial;
        work_next = stage_in.work;
        if (rem_wide >= trial)
        begin
            work_next.rem          = FREQ_W'(diff);
            work_next.quo[BIT_POS] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= stage_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && stage_in.valid)
            work_reg <= work_next;
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.work  = work_reg;

endmodule

>>> src/tfp_post.sv
module tfp_post (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tfp_pkg::tfp_stage_t             stage_in,
    input  logic                            out_stall,
    output logic                            ready,
    output logic                            out_valid,
    output logic [tfp_pkg::PERIOD_W-1:0]    timer_period
);
    import tfp_pkg::*;

    logic                valid_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;

    assign ready = !valid_reg || !out_stall;

    // Saturate, else quotient minus one, with zero quotient kept at zero
    always_comb
    begin
        if (stage_in.work.sat)
            period_next = PERIOD_MAX;
        else if (stage_in.work.quo == '0)
            period_next = '0;
        else
            period_next = stage_in.work.quo - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= stage_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && stage_in.valid)
            period_reg <= period_next;
    end

    assign out_valid    = valid_reg;
    assign timer_period = period_reg;

endmodule
